/* hw/rtl/cfd_pkg.sv */
// Package for the first-descent block: widths, reset value of the step limit,
// controller state type and the control/status structs between modules.
// No dependencies.
package cfd_pkg;

    localparam int VALUE_WIDTH = 128;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int FIELD_W     = 64;
    localparam int WORD_W      = 2 * FIELD_W;
    localparam int LIMIT_W     = 16;

    localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET = LIMIT_W'(20000);
    localparam logic [CNT_W-1:0]   LAST_BIT         = CNT_W'(VALUE_WIDTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic en;
        logic first;
    } t_pass_ctl;

    typedef struct packed {
        logic x_lt_n;
        logic peak_lt_x;
        logic ovf;
    } t_pass_stat;

    typedef struct packed {
        logic load;
        logic next_x;
        logic take_peak;
    } t_dp_ctl;

endpackage

/* hw/rtl/cfd_serial_lt.sv */
// Bit-serial unsigned less-than, LSB first: a < b over one pass.
// Depends on cfd_pkg (t_pass_ctl).
module cfd_serial_lt (
    input  logic               i_clk,
    input  cfd_pkg::t_pass_ctl i_ctl,
    input  logic               i_a_bit,
    input  logic               i_b_bit,
    output logic               o_lt
);

    logic r_lt;
    logic n_lt;
    logic lt_in;

    always_comb begin
        lt_in = i_ctl.first ? 1'b0 : r_lt;
        n_lt  = (i_a_bit != i_b_bit) ? i_b_bit : lt_in;
    end

    assign o_lt = n_lt;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_lt <= n_lt;
        end
    end

endmodule

/* hw/rtl/cfd_map_step.sv */
// Bit-serial shortcut map step: y = (3x+1)/2 for odd x, x/2 for even x,
// with overflow flag. Depends on cfd_pkg (widths, t_pass_ctl).
module cfd_map_step (
    input  logic                            i_clk,
    input  cfd_pkg::t_pass_ctl              i_ctl,
    input  logic                            i_x_bit,
    output logic [cfd_pkg::VALUE_WIDTH-1:0] o_y,
    output logic                            o_ovf
);

    logic [cfd_pkg::VALUE_WIDTH-3:0] r_y;
    logic r_odd;
    logic r_c;
    logic r_prev;

    logic odd_now;
    logic c_in;
    logic prev_in;
    logic addend;
    logic sum;
    logic cout;

    // t = x + odd * (2x + 1), one bit a cycle while i_ctl.en is high; y is t shifted down by one
    always_comb begin
        odd_now = i_ctl.first ? i_x_bit : r_odd;
        c_in    = i_ctl.first ? i_x_bit : r_c;
        prev_in = i_ctl.first ? 1'b0 : r_prev;
        addend  = odd_now & prev_in;
        sum     = i_x_bit ^ addend ^ c_in;
        cout    = (i_x_bit & addend) | (i_x_bit & c_in) | (addend & c_in);
    end

    assign o_y   = {1'b0, sum, r_y};
    assign o_ovf = (odd_now & i_x_bit) | cout;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_odd  <= odd_now;
            r_c    <= cout;
            r_prev <= i_x_bit;
            r_y    <= {sum, r_y[cfd_pkg::VALUE_WIDTH-3:1]};
        end
    end

endmodule

/* hw/rtl/cfd_ctrl.sv */
// Sequencer for the first-descent block: bit and step counters, stop
// decision, result flags. Depends on cfd_pkg (state, structs, widths).
module cfd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [cfd_pkg::LIMIT_W-1:0]   i_limit,
    input  cfd_pkg::t_pass_stat           i_stat,
    output logic                          o_busy,
    output cfd_pkg::t_pass_ctl            o_ctl,
    output cfd_pkg::t_dp_ctl              o_dp,
    output logic                          o_done,
    output logic                          o_found,
    output logic                          o_ovf,
    output logic [cfd_pkg::LIMIT_W-1:0]   o_count
);

    cfd_pkg::t_state r_state;
    cfd_pkg::t_state n_state;
    logic [cfd_pkg::CNT_W-1:0]   r_bit;
    logic [cfd_pkg::LIMIT_W-1:0] r_step;
    logic r_found;
    logic r_ovf;

    logic last;
    logic found_now;
    logic limit_hit;
    logic stop;

    always_comb begin
        last      = (r_state == cfd_pkg::ST_PASS) && (r_bit == cfd_pkg::LAST_BIT);
        found_now = (r_step != '0) && i_stat.x_lt_n;
        limit_hit = (r_step == i_limit);
        stop      = found_now || limit_hit || i_stat.ovf;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cfd_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = cfd_pkg::ST_PASS;
                end
            end
            cfd_pkg::ST_PASS: begin
                if (last && stop) begin
                    n_state = cfd_pkg::ST_DONE;
                end
            end
            cfd_pkg::ST_DONE: begin
                n_state = cfd_pkg::ST_IDLE;
            end
            default: begin
                n_state = cfd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_busy          = (r_state != cfd_pkg::ST_IDLE);
        o_ctl.en        = (r_state == cfd_pkg::ST_PASS);
        o_ctl.first     = (r_state == cfd_pkg::ST_PASS) && (r_bit == '0);
        o_dp.load       = (r_state == cfd_pkg::ST_IDLE) && i_start;
        o_dp.next_x     = last && !stop;
        o_dp.take_peak  = last && i_stat.peak_lt_x;
        o_done          = (r_state == cfd_pkg::ST_DONE);
        o_found         = r_found;
        o_ovf           = r_ovf;
        o_count         = r_found ? r_step : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cfd_pkg::ST_IDLE;
            r_bit   <= '0;
            r_step  <= '0;
            r_found <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_dp.load) begin
                r_bit   <= '0;
                r_step  <= '0;
                r_found <= 1'b0;
                r_ovf   <= 1'b0;
            end else if (r_state == cfd_pkg::ST_PASS) begin
                r_bit <= last ? '0 : r_bit + cfd_pkg::CNT_W'(1);
                if (last) begin
                    if (stop) begin
                        r_found <= found_now;
                        r_ovf   <= !found_now && !limit_hit && i_stat.ovf;
                    end else begin
                        r_step <= r_step + cfd_pkg::LIMIT_W'(1);
                    end
                end
            end
        end
    end

endmodule

/* hw/rtl/collatz_first_descent.sv */
// Top level of the first-descent block: value, start and peak shift
// registers, step limit register. Depends on cfd_pkg, cfd_ctrl,
// cfd_map_step and cfd_serial_lt.
//
// Usage: present N on i_n_low/i_n_high and raise start while busy is low;
// the word is taken at that edge. Write the step limit with i_cfg_we and
// i_cfg_data while busy is low; reset loads 20000.
// The value, N and the peak circulate LSB first through shift registers,
// one bit a cycle during each pass. Each pass checks the current value
// against N and the peak and forms the next map value at the same time.
// Passes repeat until the run stops; the result word then shows on the o_
// ports, o_done is high for exactly one cycle, and busy drops the cycle
// after. The result word holds until the next start is taken, and the
// next word can be taken once busy is low again. The receiver cannot
// stall: the receiver is to take the result word in its one cycle with
// o_done high; the block itself does not enforce it.
// Reset returns the sequencer to idle and drops any run in progress.
module collatz_first_descent (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cfg_we,
    input  logic [cfd_pkg::LIMIT_W-1:0]       i_cfg_data,
    input  logic [cfd_pkg::FIELD_W-1:0]       i_n_low,
    input  logic [cfd_pkg::FIELD_W-1:0]       i_n_high,
    output logic                              o_done,
    output logic                              o_found,
    output logic [cfd_pkg::LIMIT_W-1:0]       o_step_count,
    output logic [cfd_pkg::FIELD_W-1:0]       o_below_low,
    output logic [cfd_pkg::FIELD_W-1:0]       o_below_high,
    output logic [cfd_pkg::FIELD_W-1:0]       o_peak_low,
    output logic [cfd_pkg::FIELD_W-1:0]       o_peak_high,
    output logic                              o_overflow
);

    localparam int W = cfd_pkg::VALUE_WIDTH;

    logic [cfd_pkg::LIMIT_W-1:0] r_limit;
    logic [W-1:0] r_x;
    logic [W-1:0] r_n;
    logic [W-1:0] r_p;

    logic [cfd_pkg::WORD_W-1:0] n_word;
    logic [cfd_pkg::WORD_W-1:0] below_word;
    logic [cfd_pkg::WORD_W-1:0] peak_word;
    logic [W-1:0] y;
    logic [W-1:0] x_rot;
    logic [W-1:0] n_rot;
    logic [W-1:0] p_rot;
    logic lt_xn;
    logic lt_px;
    logic map_ovf;

    cfd_pkg::t_pass_ctl  ctl;
    cfd_pkg::t_pass_stat stat;
    cfd_pkg::t_dp_ctl    dp;

    assign n_word = {i_n_high, i_n_low};
    assign x_rot  = {r_x[0], r_x[W-1:1]};
    assign n_rot  = {r_n[0], r_n[W-1:1]};
    assign p_rot  = {r_p[0], r_p[W-1:1]};
    assign stat   = '{x_lt_n: lt_xn, peak_lt_x: lt_px, ovf: map_ovf};

    cfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_limit (r_limit),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_ctl   (ctl),
        .o_dp    (dp),
        .o_done  (o_done),
        .o_found (o_found),
        .o_ovf   (o_overflow),
        .o_count (o_step_count)
    );

    cfd_map_step u_map (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_x_bit (r_x[0]),
        .o_y     (y),
        .o_ovf   (map_ovf)
    );

    cfd_serial_lt u_lt_xn (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_a_bit (r_x[0]),
        .i_b_bit (r_n[0]),
        .o_lt    (lt_xn)
    );

    cfd_serial_lt u_lt_px (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_a_bit (r_p[0]),
        .i_b_bit (r_x[0]),
        .o_lt    (lt_px)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= cfd_pkg::STEP_LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dp.load) begin
            r_x <= n_word[W-1:0];
            r_n <= n_word[W-1:0];
            r_p <= n_word[W-1:0];
        end else if (ctl.en) begin
            r_n <= n_rot;
            r_x <= dp.next_x ? y : x_rot;
            r_p <= dp.take_peak ? x_rot : p_rot;
        end
    end

    assign below_word   = cfd_pkg::WORD_W'(r_x);
    assign peak_word    = cfd_pkg::WORD_W'(r_p);
    assign o_below_low  = below_word[cfd_pkg::FIELD_W-1:0];
    assign o_below_high = below_word[cfd_pkg::WORD_W-1:cfd_pkg::FIELD_W];
    assign o_peak_low   = peak_word[cfd_pkg::FIELD_W-1:0];
    assign o_peak_high  = peak_word[cfd_pkg::WORD_W-1:cfd_pkg::FIELD_W];

endmodule
